[hdl/pol_pkg.sv]
// pol_pkg: shared constants, command and status codes, cell control struct
// for the positional ordered list
// no dependencies
`timescale 1ns / 1ps

package pol_pkg;

    // default number of list cells
    localparam int DEPTH_DEFAULT = 16;

    // field widths
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 48;

    // command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // per-cell control from the list controller
    typedef struct packed {
        logic load;        // store the incoming value
        logic take_left;   // shift up: take the lower neighbor's entry
        logic take_right;  // shift down: take the upper neighbor's entry
        logic valid;       // cell holds a live entry
    } cell_ctrl_t;

endpackage

[hdl/positional_ordered_list_core.sv]
// positional_ordered_list_core: ordered list of signed 32-bit entries kept
// in a row of pol_cell slots, with positional commands and key search
// depends on pol_pkg, pol_cell
// a command transfer yields its registered result on m_tdata in the next cycle
// throughput: one command per cycle while the result is taken; insert/delete shift all affected cells at once
// the output register frees s_tready whenever the result is taken
// reset: rst_n clears the entry count and output valid; entries keep no reset
`timescale 1ns / 1ps

module positional_ordered_list_core
#(
    parameter int DEPTH = pol_pkg::DEPTH_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // command [2:0], position [7:3], value [39:8]
    input  logic [pol_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_value [31:0], found_position [36:32], list_length [41:37],
    // status [43:42], zero [47:44]
    output logic [pol_pkg::M_DATA_W-1:0]    m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = ((CW > pol_pkg::POS_W) ? CW : pol_pkg::POS_W) + 1;

    logic [pol_pkg::CMD_W-1:0]    cmd;
    logic [pol_pkg::POS_W-1:0]    pos;
    logic [pol_pkg::VAL_W-1:0]    val;
    logic                         take;

    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [WW-1:0]                pos_w;
    logic [WW-1:0]                cnt_w;
    logic [WW-1:0]                idx_p;
    logic                         full;
    logic                         pos_in_list;
    logic                         pos_in_ins;

    logic [pol_pkg::STATUS_W-1:0] status_c;
    logic                         do_app;
    logic                         do_ins;
    logic                         do_del;
    logic                         do_upd;
    logic                         do_read;
    logic                         do_find;

    pol_pkg::cell_ctrl_t          ctrl     [DEPTH];
    logic [pol_pkg::VAL_W-1:0]    cell_data[DEPTH];
    logic [DEPTH:0]               hit_chain;
    logic [DEPTH-1:0]             first_hit;

    logic [pol_pkg::VAL_W-1:0]    rd_c;
    logic [WW-1:0]                found_c;

    logic                         out_valid_reg;
    logic [pol_pkg::VAL_W-1:0]    rd_reg;
    logic [pol_pkg::POS_W-1:0]    found_reg;
    logic [pol_pkg::POS_W-1:0]    len_reg;
    logic [pol_pkg::STATUS_W-1:0] status_reg;

    // input unpacking and handshake
    assign cmd      = s_tdata[2:0];
    assign pos      = s_tdata[7:3];
    assign val      = s_tdata[39:8];
    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    // position range checks
    assign pos_w       = WW'(pos);
    assign cnt_w       = WW'(count_reg);
    assign idx_p       = pos_w - WW'(1);
    assign full        = (cnt_w == WW'(DEPTH));
    assign pos_in_list = (pos_w != '0) && (pos_w <= cnt_w);
    assign pos_in_ins  = (pos_w != '0) && (pos_w <= cnt_w + WW'(1));

    // command decode
    always_comb
    begin
        status_c = pol_pkg::ST_OK;
        do_app   = 1'b0;
        do_ins   = 1'b0;
        do_del   = 1'b0;
        do_upd   = 1'b0;
        do_read  = 1'b0;
        do_find  = 1'b0;
        unique case (cmd)
            pol_pkg::CMD_APPEND:
            begin
                if (full) status_c = pol_pkg::ST_FULL;
                else      do_app   = 1'b1;
            end
            pol_pkg::CMD_INSERT:
            begin
                if (full)             status_c = pol_pkg::ST_FULL;
                else if (!pos_in_ins) status_c = pol_pkg::ST_RANGE;
                else                  do_ins   = 1'b1;
            end
            pol_pkg::CMD_DELETE:
            begin
                if (!pos_in_list) status_c = pol_pkg::ST_RANGE;
                else              do_del   = 1'b1;
            end
            pol_pkg::CMD_UPDATE:
            begin
                if (!pos_in_list) status_c = pol_pkg::ST_RANGE;
                else              do_upd   = 1'b1;
            end
            pol_pkg::CMD_READ:
            begin
                if (!pos_in_list) status_c = pol_pkg::ST_RANGE;
                else              do_read  = 1'b1;
            end
            pol_pkg::CMD_FIND:
            begin
                do_find = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (take && (do_app || do_ins))
        begin
            count_next = count_reg + CW'(1);
        end
        else if (take && do_del)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // row of cells
    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [WW-1:0] IDX = WW'(i);
        logic [pol_pkg::VAL_W-1:0] left_d;
        logic [pol_pkg::VAL_W-1:0] right_d;

        assign ctrl[i].load       = take && ((do_app && (IDX == cnt_w))
                                    || ((do_ins || do_upd) && (IDX == idx_p)));
        assign ctrl[i].take_left  = take && do_ins && (IDX > idx_p) && (IDX <= cnt_w);
        assign ctrl[i].take_right = take && do_del && (IDX >= idx_p)
                                    && (IDX + WW'(1) < cnt_w);
        assign ctrl[i].valid      = (IDX < cnt_w);

        if (i == 0)
        begin : g_first
            assign left_d = cell_data[i];
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        pol_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl[i]),
            .value      (val),
            .left_data  (left_d),
            .right_data (right_d),
            .hit_in     (hit_chain[i]),
            .hit_out    (hit_chain[i+1]),
            .first_hit  (first_hit[i]),
            .data       (cell_data[i])
        );
    end

    // read select and found position encode
    always_comb
    begin
        rd_c    = '0;
        found_c = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (do_read && (idx_p == WW'(i)))
            begin
                rd_c = rd_c | cell_data[i];
            end
            if (do_find && first_hit[i])
            begin
                found_c = found_c | WW'(i + 1);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rd_reg     <= rd_c;
            found_reg  <= found_c[pol_pkg::POS_W-1:0];
            len_reg    <= pol_pkg::POS_W'(count_next);
            status_reg <= status_c;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, status_reg, len_reg, found_reg, rd_reg};

endmodule

[hdl/pol_cell.sv]
// pol_cell: one list slot, holds a 32-bit entry, shifts to/from neighbors
// and compares its entry against the search key in a ripple hit chain
// depends on pol_pkg
`timescale 1ns / 1ps

module pol_cell
(
    input  logic                            clk,
    input  pol_pkg::cell_ctrl_t             ctrl,
    input  logic [pol_pkg::VAL_W-1:0]       value,
    input  logic [pol_pkg::VAL_W-1:0]       left_data,
    input  logic [pol_pkg::VAL_W-1:0]       right_data,
    input  logic                            hit_in,
    output logic                            hit_out,
    output logic                            first_hit,
    output logic [pol_pkg::VAL_W-1:0]       data
);

    logic [pol_pkg::VAL_W-1:0] data_reg;
    logic [pol_pkg::VAL_W-1:0] data_next;
    logic                      match;

    // entry update: load, shift up, shift down or hold
    always_comb
    begin
        priority if (ctrl.load)
        begin
            data_next = value;
        end
        else if (ctrl.take_left)
        begin
            data_next = left_data;
        end
        else if (ctrl.take_right)
        begin
            data_next = right_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // key compare, first live match along the chain
    assign match     = ctrl.valid && (data_reg == value);
    assign first_hit = match && !hit_in;
    assign hit_out   = match || hit_in;
    assign data      = data_reg;

endmodule

[hdl/pol_checker.sv]
// pol_port_checker: port-level assertions for positional_ordered_list_core
// depends on pol_pkg; bound to the top level below
`timescale 1ns / 1ps

module pol_port_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [pol_pkg::S_DATA_W-1:0]    s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pol_pkg::M_DATA_W-1:0]    m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // every command transfer gives a result next cycle
    a_resp: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("command transfer gave no result");

    // status code is always a defined one
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[43:42] == pol_pkg::ST_OK
                   || m_tdata[43:42] == pol_pkg::ST_FULL
                   || m_tdata[43:42] == pol_pkg::ST_RANGE))
        else $error("undefined status code");

    // a failed command reports no read value and no found position
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[43:42] != pol_pkg::ST_OK)
        |-> (m_tdata[31:0] == '0) && (m_tdata[36:32] == '0))
        else $error("failed command carries data");

endmodule

bind positional_ordered_list_core pol_port_checker u_pol_port_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
